@@ rtl/complex_number_alu_macros.svh @@
// Assertion macros shared by the complex ALU checker.
`ifndef COMPLEX_NUMBER_ALU_MACROS_SVH
`define COMPLEX_NUMBER_ALU_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CNA_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("complex ALU check failed");

// Next-cycle implication, disabled in reset.
`define CNA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("complex ALU check failed");

`endif

@@ rtl/cna_pkg.sv @@
// ----------------------------------------------------------------------------
// cna_pkg
// Command and status codes and default widths of the complex ALU.
// ----------------------------------------------------------------------------
package cna_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_SUB = 4'd1,
		CMD_MUL = 4'd2,
		CMD_DIV = 4'd3,
		CMD_NEG = 4'd4,
		CMD_EQ  = 4'd5,
		CMD_NE  = 4'd6,
		CMD_LT  = 4'd7,
		CMD_GT  = 4'd8,
		CMD_LE  = 4'd9,
		CMD_GE  = 4'd10
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NO_CMP = 2'd1,
		ST_DIV0   = 2'd2,
		ST_SAT    = 2'd3
	} status_t;

endpackage

@@ rtl/complex_number_alu.sv @@
// ----------------------------------------------------------------------------
// complex_number_alu
// Pipelined complex add/sub/mul/div/negate and compares on signed fixed point.
// ----------------------------------------------------------------------------
// One word enters per cycle unless the pipe is held, and passes through one
// stage of products, one of sums, one of rounding and divide setup, one
// restoring-divide stage per quotient bit, and the output register. The
// pipeline advances as a whole; it holds while the output word is stalled,
// so in_stall follows out_valid and out_stall.
module complex_number_alu #(
	parameter int WORD_BITS = cna_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [3:0]                  cmd,
	input  logic signed [WORD_BITS-1:0] a_re,
	input  logic signed [WORD_BITS-1:0] a_im,
	input  logic signed [WORD_BITS-1:0] b_re,
	input  logic signed [WORD_BITS-1:0] b_im,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WORD_BITS-1:0] res_re,
	output logic signed [WORD_BITS-1:0] res_im,
	output logic                        cmp_true,
	output logic [1:0]                  status
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;
	localparam int DW = 2 * W + 1;
	localparam int QB = W;
	localparam int RW = 3 * W + F + 1;

	localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = ~MAXV;
	localparam logic [W:0] HALF = {2'b01, {(W-1){1'b0}}};

	typedef struct packed {
		logic             valid;
		logic [3:0]       cmd;
		logic [W-1:0]     res_re;
		logic [W-1:0]     res_im;
		logic             cmp;
		logic [1:0]       status;
		logic [RW-1:0]    rem_re;
		logic [RW-1:0]    rem_im;
		logic [QB-1:0]    q_re;
		logic [QB-1:0]    q_im;
		logic             neg_re;
		logic             neg_im;
		logic             ovr_re;
		logic             ovr_im;
		logic             dz;
		logic [DW-1:0]    den;
	} dv_t;

	function automatic logic signed [SW-1:0] sx(input logic [W-1:0] x);
		sx = signed'({{(SW-W){x[W-1]}}, x});
	endfunction

	// {saturated, value}
	function automatic logic [W:0] clamp(input logic signed [SW-1:0] v);
		if (v > MAXV) begin
			clamp = {1'b1, MAXV[W-1:0]};
		end else if (v < MINV) begin
			clamp = {1'b1, MINV[W-1:0]};
		end else begin
			clamp = {1'b0, v[W-1:0]};
		end
	endfunction

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// ---------------- stage 1: operands and products
	logic                 v_s1;
	logic [3:0]           cmd_s1;
	logic signed [W-1:0]  ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, p_bb_s1, p_cc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= cmd;
			ar_s1   <= a_re;
			ai_s1   <= a_im;
			br_s1   <= b_re;
			bi_s1   <= b_im;
			p_rr_s1 <= PW'(a_re) * PW'(b_re);
			p_ii_s1 <= PW'(a_im) * PW'(b_im);
			p_ir_s1 <= PW'(a_im) * PW'(b_re);
			p_ri_s1 <= PW'(a_re) * PW'(b_im);
			p_bb_s1 <= PW'(b_re) * PW'(b_re);
			p_cc_s1 <= PW'(b_im) * PW'(b_im);
		end
	end

	// ---------------- stage 2: sums of products
	logic                 v_s2;
	logic [3:0]           cmd_s2;
	logic signed [W-1:0]  ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [SW-1:0] mre_s2, mim_s2, nre_s2, nim_s2;
	logic [DW-1:0]        den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= cmd_s1;
			ar_s2  <= ar_s1;
			ai_s2  <= ai_s1;
			br_s2  <= br_s1;
			bi_s2  <= bi_s1;
			mre_s2 <= SW'(p_rr_s1) - SW'(p_ii_s1);
			mim_s2 <= SW'(p_ir_s1) + SW'(p_ri_s1);
			nre_s2 <= SW'(p_rr_s1) + SW'(p_ii_s1);
			nim_s2 <= SW'(p_ir_s1) - SW'(p_ri_s1);
			den_s2 <= DW'(unsigned'(p_bb_s1)) + DW'(unsigned'(p_cc_s1));
		end
	end

	// ---------------- stage 3: rounding, compares, divide setup
	dv_t dv_s [0:QB];
	dv_t s3_d;

	always_comb begin
		logic signed [SW-1:0] x, y;
		logic [SW-1:0]        mre, mim;
		logic [W:0]           cr, ci;
		logic                 ordered;
		s3_d       = '0;
		s3_d.valid = v_s2;
		s3_d.cmd   = cmd_s2;
		s3_d.den   = den_s2;
		s3_d.dz    = (br_s2 == '0) && (bi_s2 == '0);
		x = '0;
		y = '0;
		unique case (cmd_s2)
			cna_pkg::CMD_ADD: begin
				x = sx(ar_s2) + sx(br_s2);
				y = sx(ai_s2) + sx(bi_s2);
			end
			cna_pkg::CMD_SUB: begin
				x = sx(ar_s2) - sx(br_s2);
				y = sx(ai_s2) - sx(bi_s2);
			end
			cna_pkg::CMD_MUL: begin
				x = mre_s2 >>> F;
				y = mim_s2 >>> F;
			end
			cna_pkg::CMD_NEG: begin
				x = -sx(ar_s2);
				y = -sx(ai_s2);
			end
			default: begin
				x = '0;
				y = '0;
			end
		endcase
		cr = clamp(x);
		ci = clamp(y);
		s3_d.res_re = cr[W-1:0];
		s3_d.res_im = ci[W-1:0];
		if (cr[W] || ci[W]) begin
			s3_d.status = cna_pkg::ST_SAT;
		end
		ordered = (ai_s2 == '0) && (bi_s2 == '0);
		unique case (cmd_s2)
			cna_pkg::CMD_EQ: s3_d.cmp = (ar_s2 == br_s2) && (ai_s2 == bi_s2);
			cna_pkg::CMD_NE: s3_d.cmp = (ar_s2 != br_s2) || (ai_s2 != bi_s2);
			cna_pkg::CMD_LT: s3_d.cmp = ordered && (ar_s2 < br_s2);
			cna_pkg::CMD_GT: s3_d.cmp = ordered && (ar_s2 > br_s2);
			cna_pkg::CMD_LE: s3_d.cmp = ordered && (ar_s2 <= br_s2);
			cna_pkg::CMD_GE: s3_d.cmp = ordered && (ar_s2 >= br_s2);
			default:         s3_d.cmp = 1'b0;
		endcase
		if (!ordered && (cmd_s2 == cna_pkg::CMD_LT || cmd_s2 == cna_pkg::CMD_GT ||
				cmd_s2 == cna_pkg::CMD_LE || cmd_s2 == cna_pkg::CMD_GE)) begin
			s3_d.status = cna_pkg::ST_NO_CMP;
		end
		s3_d.neg_re = nre_s2[SW-1];
		s3_d.neg_im = nim_s2[SW-1];
		mre = nre_s2[SW-1] ? unsigned'(-nre_s2) : unsigned'(nre_s2);
		mim = nim_s2[SW-1] ? unsigned'(-nim_s2) : unsigned'(nim_s2);
		s3_d.rem_re = RW'(mre) << F;
		s3_d.rem_im = RW'(mim) << F;
		// quotient would need more than QB bits
		s3_d.ovr_re = s3_d.rem_re >= (RW'(den_s2) << QB);
		s3_d.ovr_im = s3_d.rem_im >= (RW'(den_s2) << QB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0].valid <= 1'b0;
		end else if (adv) begin
			dv_s[0] <= s3_d;
		end
	end

	// ---------------- restoring divide, one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int BIT = QB - 1 - k;
		dv_t nx;

		always_comb begin
			logic [RW-1:0] t;
			nx = dv_s[k];
			t  = RW'(dv_s[k].den) << BIT;
			if (dv_s[k].rem_re >= t) begin
				nx.rem_re    = dv_s[k].rem_re - t;
				nx.q_re[BIT] = 1'b1;
			end
			if (dv_s[k].rem_im >= t) begin
				nx.rem_im    = dv_s[k].rem_im - t;
				nx.q_im[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1].valid <= 1'b0;
			end else if (adv) begin
				dv_s[k+1] <= nx;
			end
		end
	end

	// ---------------- output: floor, saturate, select
	dv_t               fin;
	logic [W-1:0]      o_re, o_im;
	logic              o_cmp;
	logic [1:0]        o_st;

	assign fin = dv_s[QB];

	function automatic logic [W:0] div_fin(input logic [QB-1:0] q, input logic neg,
			input logic inexact, input logic ovr);
		logic [W:0] m;
		logic       over;
		m    = {1'b0, q} + {{W{1'b0}}, neg & inexact};
		over = ovr || (neg ? (m > HALF) : (m > HALF - 1'b1));
		if (over) begin
			div_fin = {1'b1, neg ? MINV[W-1:0] : MAXV[W-1:0]};
		end else begin
			div_fin = {1'b0, neg ? -m[W-1:0] : m[W-1:0]};
		end
	endfunction

	always_comb begin
		logic [W:0] dr, di;
		dr    = div_fin(fin.q_re, fin.neg_re, fin.rem_re != '0, fin.ovr_re);
		di    = div_fin(fin.q_im, fin.neg_im, fin.rem_im != '0, fin.ovr_im);
		o_re  = fin.res_re;
		o_im  = fin.res_im;
		o_cmp = fin.cmp;
		o_st  = fin.status;
		if (fin.cmd == cna_pkg::CMD_DIV) begin
			o_cmp = 1'b0;
			if (fin.dz) begin
				o_re = '0;
				o_im = '0;
				o_st = cna_pkg::ST_DIV0;
			end else begin
				o_re = dr[W-1:0];
				o_im = di[W-1:0];
				o_st = (dr[W] || di[W]) ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_re   <= o_re;
			res_im   <= o_im;
			cmp_true <= o_cmp;
			status   <= o_st;
		end
	end

endmodule

@@ rtl/cna_checker.sv @@
// ----------------------------------------------------------------------------
// cna_checker
// Port-level checks of the complex ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_number_alu_macros.svh"

module cna_checker #(
	parameter int WORD_BITS = cna_pkg::WORD_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [WORD_BITS-1:0] res_re,
	input logic [WORD_BITS-1:0] res_im,
	input logic                 cmp_true,
	input logic [1:0]           status
);

	// the pipe holds exactly when the output word is held
	`CNA_ASSERT_IMPL(a_stall_link, clk, arst_n, 1'b1, in_stall == (out_valid && out_stall))
	`CNA_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(res_re) && $stable(status))
	`CNA_ASSERT_IMPL(a_div0_zero, clk, arst_n, out_valid && status == cna_pkg::ST_DIV0, res_re == '0 && res_im == '0 && !cmp_true)
	`CNA_ASSERT_IMPL(a_cmp_ok, clk, arst_n, out_valid && cmp_true, status == cna_pkg::ST_OK && res_re == '0)

endmodule

bind complex_number_alu cna_checker #(.WORD_BITS(WORD_BITS)) u_cna_checker (.*);
